@@ sv/lfcq_pkg.sv @@
// Package for the length-framed command queue.
// Holds function codes, status codes and default sizes; no dependencies.
package lfcq_pkg;

    localparam int BUFFER_BYTES_DEF = 64;
    localparam int MAX_PAYLOAD_DEF  = 14;
    localparam int RESULT_LIMIT     = 16;

    localparam logic [2:0] F_HEADER  = 3'd0;
    localparam logic [2:0] F_PAYLOAD = 3'd1;
    localparam logic [2:0] F_POP     = 3'd2;
    localparam logic [2:0] F_READ    = 3'd3;
    localparam logic [2:0] F_FLUSH   = 3'd4;

    localparam logic [2:0] ST_GOOD     = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_BAD      = 3'd3;
    localparam logic [2:0] ST_OVERSIZE = 3'd4;

endpackage

@@ sv/length_framed_command_queue.sv @@
// Length-framed command queue: a ring of command bytes in one synchronous memory.
// Depends on lfcq_pkg for codes and default sizes.
//
//   channel  | handshake               | beat
//   ---------+-------------------------+------------------------------------------
//   in       | in_valid / in_ready     | func, cmd_id, payload_len, data_byte
//   out      | out_valid / out_ready   | status, is_data, out_byte, last
//   cfg      | cfg_we                  | cfg_wdata (reject_zero_id)
//
// Payload beats, flushes, rejected headers and empty pops or reads are answered from S_IDLE.
// Accepted headers write the id, then the length in S_HDR2 (id and length share the one write port);
// pops read the length, then answer from S_POP. A read fetches the length through S_RD_LEN,
// then streams one byte per cycle unless out_ready stalls it, 2 + length beats capped at 16.
// Reset clears the control state and sets reject_zero_id; the byte store is not cleared.
// A low out_ready holds the output beat and stops both streaming and input acceptance.
module length_framed_command_queue #(
    parameter int BUFFER_BYTES = lfcq_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_PAYLOAD  = lfcq_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] func,
    input  logic [7:0] cmd_id,
    input  logic [7:0] payload_len,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic       is_data,
    output logic [7:0] out_byte,
    output logic       last
);

    localparam int IW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int UW = $clog2(BUFFER_BYTES + 1);
    localparam int CW = $clog2(lfcq_pkg::RESULT_LIMIT + 1);

    typedef enum logic [2:0] {S_IDLE, S_HDR2, S_POP, S_RD_LEN, S_RD_DATA} state_t;

    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a, input logic [UW-1:0] b);
        logic [UW:0] sum;
        sum = (UW+1)'(a) + (UW+1)'(b);
        if (sum >= (UW+1)'(BUFFER_BYTES))
            sum = sum - (UW+1)'(BUFFER_BYTES);
        return IW'(sum);
    endfunction

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] a);
        if (a == IW'(BUFFER_BYTES - 1))
            return '0;
        return a + IW'(1);
    endfunction

    logic [7:0] mem [BUFFER_BYTES];
    logic       mem_we;
    logic       mem_re;
    logic [IW-1:0] mem_waddr;
    logic [IW-1:0] mem_raddr;
    logic [7:0] mem_wdata;
    logic [7:0] rdata_reg;

    state_t     state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [UW-1:0] used_reg, used_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic [7:0] pend_rem_reg, pend_rem_next;
    logic [7:0] open_len_reg, open_len_next;
    logic       write_open_reg, write_open_next;
    logic       reject_zero_reg;
    logic [IW-1:0] addr_reg, addr_next;
    logic [7:0] wdata_reg, wdata_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] status_reg, status_next;
    logic       is_data_reg, is_data_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       last_reg, last_next;

    logic       out_free;
    logic [IW-1:0] tail;
    logic [9:0] need;
    logic [9:0] pop_size;
    logic [8:0] rd_count;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign is_data   = is_data_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    assign tail     = ring_add(head_reg, used_reg);
    assign need     = 10'(used_reg) + 10'd2 + 10'(payload_len);
    assign pop_size = (10'd2 + 10'(rdata_reg) > 10'(used_reg)) ? 10'(used_reg)
                                                             : 10'd2 + 10'(rdata_reg);
    assign rd_count = 9'd2 + 9'(rdata_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        used_next       = used_reg;
        pend_idx_next   = pend_idx_reg;
        pend_rem_next   = pend_rem_reg;
        open_len_next   = open_len_reg;
        write_open_next = write_open_reg;
        addr_next       = addr_reg;
        wdata_next      = wdata_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        is_data_next    = is_data_reg;
        out_byte_next   = out_byte_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = wdata_reg;
        mem_re          = 1'b0;
        mem_raddr       = addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = lfcq_pkg::ST_GOOD;
                    is_data_next   = 1'b0;
                    out_byte_next  = 8'd0;
                    last_next      = 1'b1;
                    case (func)
                        lfcq_pkg::F_HEADER:
                        begin
                            if (write_open_reg)
                                status_next = lfcq_pkg::ST_BAD;
                            else if (reject_zero_reg && cmd_id == 8'd0)
                                status_next = lfcq_pkg::ST_BAD;
                            else if (need > 10'(BUFFER_BYTES))
                                status_next = lfcq_pkg::ST_FULL;
                            else if (payload_len > 8'(MAX_PAYLOAD))
                                status_next = lfcq_pkg::ST_OVERSIZE;
                            else
                            begin
                                mem_we        = 1'b1;
                                mem_waddr     = tail;
                                mem_wdata     = cmd_id;
                                addr_next     = ring_inc(tail);
                                wdata_next    = payload_len;
                                pend_idx_next = ring_inc(ring_inc(tail));
                                state_next    = S_HDR2;
                                if (payload_len == 8'd0)
                                begin
                                    used_next     = used_reg + UW'(2);
                                    pend_rem_next = 8'd0;
                                end
                                else
                                begin
                                    pend_rem_next   = payload_len;
                                    open_len_next   = payload_len;
                                    write_open_next = 1'b1;
                                end
                            end
                        end
                        lfcq_pkg::F_PAYLOAD:
                        begin
                            if (!write_open_reg)
                                status_next = lfcq_pkg::ST_BAD;
                            else
                            begin
                                mem_we        = 1'b1;
                                mem_waddr     = pend_idx_reg;
                                mem_wdata     = data_byte;
                                pend_idx_next = ring_inc(pend_idx_reg);
                                pend_rem_next = pend_rem_reg - 8'd1;
                                if (pend_rem_reg == 8'd1)
                                begin
                                    used_next       = UW'(10'(used_reg) + 10'd2
                                                          + 10'(open_len_reg));
                                    write_open_next = 1'b0;
                                end
                            end
                        end
                        lfcq_pkg::F_POP,
                        lfcq_pkg::F_READ:
                        begin
                            if (used_reg == '0)
                                status_next = lfcq_pkg::ST_EMPTY;
                            else
                            begin
                                out_valid_next = 1'b0;
                                mem_re         = 1'b1;
                                mem_raddr      = ring_inc(head_reg);
                                state_next     = (func == lfcq_pkg::F_POP) ? S_POP : S_RD_LEN;
                            end
                        end
                        lfcq_pkg::F_FLUSH:
                        begin
                            head_next       = '0;
                            used_next       = '0;
                            pend_idx_next   = '0;
                            pend_rem_next   = 8'd0;
                            write_open_next = 1'b0;
                            status_next     = lfcq_pkg::ST_EMPTY;
                        end
                        default:
                        begin
                            status_next = lfcq_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            S_HDR2:
            begin
                mem_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_POP:
            begin
                head_next      = ring_add(head_reg, UW'(pop_size));
                used_next      = used_reg - UW'(pop_size);
                out_valid_next = 1'b1;
                status_next    = lfcq_pkg::ST_GOOD;
                is_data_next   = 1'b0;
                out_byte_next  = 8'd0;
                last_next      = 1'b1;
                state_next     = S_IDLE;
            end
            S_RD_LEN:
            begin
                cnt_next   = (rd_count > 9'(lfcq_pkg::RESULT_LIMIT))
                             ? CW'(lfcq_pkg::RESULT_LIMIT) : CW'(rd_count);
                mem_re     = 1'b1;
                mem_raddr  = head_reg;
                addr_next  = ring_inc(head_reg);
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = lfcq_pkg::ST_GOOD;
                    is_data_next   = 1'b1;
                    out_byte_next  = rdata_reg;
                    last_next      = (cnt_reg == CW'(1));
                    if (cnt_reg == CW'(1))
                        state_next = S_IDLE;
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = addr_reg;
                        addr_next = ring_inc(addr_reg);
                        cnt_next  = cnt_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            used_reg        <= '0;
            pend_idx_reg    <= '0;
            pend_rem_reg    <= 8'd0;
            write_open_reg  <= 1'b0;
            reject_zero_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            used_reg       <= used_next;
            pend_idx_reg   <= pend_idx_next;
            pend_rem_reg   <= pend_rem_next;
            write_open_reg <= write_open_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
                reject_zero_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        open_len_reg <= open_len_next;
        addr_reg     <= addr_next;
        wdata_reg    <= wdata_next;
        cnt_reg      <= cnt_next;
        status_reg   <= status_next;
        is_data_reg  <= is_data_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

endmodule

@@ sv/lfcq_checker.sv @@
// Port-level checks for the length-framed command queue, bound to its top level.
// Depends on lfcq_pkg for status codes.
module lfcq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic       is_data,
    input logic [7:0] out_byte,
    input logic       last
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_byte)
                                    && $stable(is_data) && $stable(last))
        else $error("Stalled output beat changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_data |-> status == lfcq_pkg::ST_GOOD)
        else $error("Data beat carries a failing status.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_data |-> last && out_byte == 8'd0)
        else $error("Status beat is not a single zero-byte last beat.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= lfcq_pkg::ST_OVERSIZE)
        else $error("Status code out of range.");

endmodule

bind length_framed_command_queue lfcq_checker u_lfcq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .is_data   (is_data),
    .out_byte  (out_byte),
    .last      (last)
);
